// File: src/rci_pkg.sv
// ----------------------------------------------------------------------------
// rci_pkg
// Shared types and constants for the RGB to color index converter.
// ----------------------------------------------------------------------------
package rci_pkg;

   localparam int CH_W       = 8;
   localparam int LANE_W     = 16;
   localparam int PIX_W      = 24;
   localparam int IDX_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [IDX_W-1:0] INDEX_MAX = 8'd255;

   typedef enum logic [1:0] {
      MODE_DIRECT    = 2'd0,
      MODE_COMPONENT = 2'd1,
      MODE_RANGE     = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COLOR_MODE        = 3'd0,
      REG_COMPONENT_WEIGHTS = 3'd1,
      REG_COMPONENT_MASKS   = 3'd2,
      REG_RANGE_WEIGHTS     = 3'd3,
      REG_RANGE_BASE        = 3'd4,
      REG_RANGE_LIMIT       = 3'd5,
      REG_RANGE_SCALE       = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [1:0]        color_mode;
      logic [47:0]       component_weights;
      logic [47:0]       component_masks;
      logic [47:0]       range_weights;
      logic signed [8:0] range_base;
      logic [7:0]        range_limit;
      logic [15:0]       range_scale;
   } cfg_type;

   localparam logic [7:0]  RANGE_LIMIT_RST = 8'd255;
   localparam logic [15:0] RANGE_SCALE_RST = 16'd256;

endpackage

// File: src/rci_if.sv
// ----------------------------------------------------------------------------
// rci_if
// Valid/ready channels for pixel requests and converted pixel responses.
// ----------------------------------------------------------------------------
interface rci_req_if
   import rci_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red;
   logic [CH_W-1:0] green;
   logic [CH_W-1:0] blue;
   logic            end_of_line;

   modport source (output valid, red, green, blue, end_of_line, input ready);
   modport sink   (input valid, red, green, blue, end_of_line, output ready);
endinterface

interface rci_rsp_if
   import rci_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             is_index;
   logic             end_of_line_out;

   modport source (output valid, pixel_out, is_index, end_of_line_out, input ready);
   modport sink   (input valid, pixel_out, is_index, end_of_line_out, output ready);
endinterface

// File: src/rci_csr.sv
// ----------------------------------------------------------------------------
// rci_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module rci_csr
   import rci_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_COLOR_MODE:        cfg_in.color_mode        = csr_wdata[1:0];
            REG_COMPONENT_WEIGHTS: cfg_in.component_weights = csr_wdata[47:0];
            REG_COMPONENT_MASKS:   cfg_in.component_masks   = csr_wdata[47:0];
            REG_RANGE_WEIGHTS:     cfg_in.range_weights     = csr_wdata[47:0];
            REG_RANGE_BASE:        cfg_in.range_base        = $signed(csr_wdata[8:0]);
            REG_RANGE_LIMIT:       cfg_in.range_limit       = csr_wdata[7:0];
            REG_RANGE_SCALE:       cfg_in.range_scale       = csr_wdata[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color_mode        <= MODE_DIRECT;
         cfg_ff.component_weights <= '0;
         cfg_ff.component_masks   <= '0;
         cfg_ff.range_weights     <= '0;
         cfg_ff.range_base        <= '0;
         cfg_ff.range_limit       <= RANGE_LIMIT_RST;
         cfg_ff.range_scale       <= RANGE_SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/rgb_to_color_index_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_color_index_converter_unit
// Converts RGB pixels to packed direct color or to a color index.
//
// One pixel beat enters and one result beat leaves per clock while the
// response side is ready. The four-stage pipeline holds the channel-by-weight
// multiplies, the component sum and weighted range sum, the multiply by the
// range scale, and the base add, cap, clamp and mode select into the output
// register. Each stage holds its beat only while the stage after it is full
// and stalled, so bubbles collapse and requests still enter empty stages
// while a response waits. The user must write configuration through the
// csr_ port only while no beat is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module rgb_to_color_index_converter_unit
   import rci_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rci_req_if.sink               req_bus,
   rci_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   rci_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // stage valids and advance
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   assign s4_ready      = !s4_valid_ff || rsp_bus.ready;
   assign s3_ready      = !s3_valid_ff || s4_ready;
   assign s2_ready      = !s2_valid_ff || s3_ready;
   assign s1_ready      = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;

   // stage 1: channel products
   logic [PIX_W-1:0] s1_rgb_ff,  s1_rgb_in;
   logic             s1_eol_ff;
   logic [23:0]      s1_cprod_ff [3];
   logic [23:0]      s1_cprod_in [3];
   logic [23:0]      s1_rprod_ff [3];
   logic [23:0]      s1_rprod_in [3];

   always_comb begin
      s1_rgb_in      = {req_bus.red, req_bus.green, req_bus.blue};
      s1_cprod_in[0] = 24'(cfg.component_weights[47:32]) * 24'(req_bus.red);
      s1_cprod_in[1] = 24'(cfg.component_weights[31:16]) * 24'(req_bus.green);
      s1_cprod_in[2] = 24'(cfg.component_weights[15:0])  * 24'(req_bus.blue);
      s1_rprod_in[0] = 24'(cfg.range_weights[47:32]) * 24'(req_bus.red);
      s1_rprod_in[1] = 24'(cfg.range_weights[31:16]) * 24'(req_bus.green);
      s1_rprod_in[2] = 24'(cfg.range_weights[15:0])  * 24'(req_bus.blue);
   end

   // stage 2: component index and weighted range sum
   logic [PIX_W-1:0] s2_rgb_ff;
   logic             s2_eol_ff;
   logic [IDX_W-1:0] s2_cidx_ff, s2_cidx_in;
   logic [25:0]      s2_wsum_ff, s2_wsum_in;
   logic [17:0]      csum;

   always_comb begin
      csum = {2'b00, s1_cprod_ff[0][23:8] & cfg.component_masks[47:32]}
           + {2'b00, s1_cprod_ff[1][23:8] & cfg.component_masks[31:16]}
           + {2'b00, s1_cprod_ff[2][23:8] & cfg.component_masks[15:0]};
      s2_cidx_in = (csum > 18'(INDEX_MAX)) ? INDEX_MAX : csum[IDX_W-1:0];
      s2_wsum_in = {2'b00, s1_rprod_ff[0]} + {2'b00, s1_rprod_ff[1]}
                 + {2'b00, s1_rprod_ff[2]};
   end

   // stage 3: scale multiply
   logic [PIX_W-1:0] s3_rgb_ff;
   logic             s3_eol_ff;
   logic [IDX_W-1:0] s3_cidx_ff;
   logic [41:0]      s3_scaled_ff, s3_scaled_in;

   assign s3_scaled_in = 42'(s2_wsum_ff) * 42'(cfg.range_scale);

   // stage 4: base, cap, clamp, mode select
   logic [PIX_W-1:0]  s4_pixel_ff, s4_pixel_in;
   logic              s4_is_index_ff, s4_is_index_in;
   logic              s4_eol_ff;
   logic signed [21:0] ridx_sum;
   logic [IDX_W-1:0]  ridx;

   always_comb begin
      ridx_sum = $signed({2'b00, s3_scaled_ff[41:22]})
               + $signed({{13{cfg.range_base[8]}}, cfg.range_base});
      if (ridx_sum > $signed({14'd0, cfg.range_limit})) begin
         ridx = cfg.range_limit;
      end else if (ridx_sum[21]) begin
         ridx = '0;
      end else begin
         ridx = ridx_sum[IDX_W-1:0];
      end
      case (cfg.color_mode)
         MODE_DIRECT: begin
            s4_pixel_in    = s3_rgb_ff;
            s4_is_index_in = 1'b0;
         end
         MODE_COMPONENT: begin
            s4_pixel_in    = {16'd0, s3_cidx_ff};
            s4_is_index_in = 1'b1;
         end
         MODE_RANGE: begin
            s4_pixel_in    = {16'd0, ridx};
            s4_is_index_in = 1'b1;
         end
         default: begin
            s4_pixel_in    = '0;
            s4_is_index_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_bus.valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_rgb_ff   <= s1_rgb_in;
         s1_eol_ff   <= req_bus.end_of_line;
         s1_cprod_ff <= s1_cprod_in;
         s1_rprod_ff <= s1_rprod_in;
      end
      if (s2_ready) begin
         s2_rgb_ff  <= s1_rgb_ff;
         s2_eol_ff  <= s1_eol_ff;
         s2_cidx_ff <= s2_cidx_in;
         s2_wsum_ff <= s2_wsum_in;
      end
      if (s3_ready) begin
         s3_rgb_ff    <= s2_rgb_ff;
         s3_eol_ff    <= s2_eol_ff;
         s3_cidx_ff   <= s2_cidx_ff;
         s3_scaled_ff <= s3_scaled_in;
      end
      if (s4_ready) begin
         s4_pixel_ff    <= s4_pixel_in;
         s4_is_index_ff <= s4_is_index_in;
         s4_eol_ff      <= s3_eol_ff;
      end
   end

   assign rsp_bus.valid           = s4_valid_ff;
   assign rsp_bus.pixel_out       = s4_pixel_ff;
   assign rsp_bus.is_index        = s4_is_index_ff;
   assign rsp_bus.end_of_line_out = s4_eol_ff;

`ifndef SYNTHESIS
   // accepted beat always lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> s1_valid_ff)
      else $error("accepted beat lost at stage 1");

   // index results fit in one byte
   a_index_narrow: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.is_index |-> rsp_bus.pixel_out[23:8] == 16'd0)
      else $error("index result wider than a byte");

   // full stalled stage 3 never drops its beat
   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !s4_ready |=> s3_valid_ff && $stable(s3_scaled_ff))
      else $error("stage 3 beat changed under stall");
`endif

endmodule

// File: bench/rci_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rci_pixel_checker
// Watches the pixel request and response channels and the csr_ write port of
// the color index converter. Keeps a shadow copy of the registers, converts
// every accepted request beat into its expected response, and compares each
// accepted response beat field by field against the oldest pending one.
// ----------------------------------------------------------------------------
module rci_pixel_checker
   import rci_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rci_req_if                    req_mon,
   rci_rsp_if                    rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             is_index;
      logic             end_of_line_out;
   } converted_pixel_type;

   cfg_type             shadow_cfg;
   converted_pixel_type expected_pixels[$];
   int                  errors = 0;

   // lane 0 red, 1 green, 2 blue
   function automatic longint lane_of(logic [CSR_DATA_W-1:0] word, int lane);
      return longint'(word[(2 - lane) * LANE_W +: LANE_W]);
   endfunction

   function automatic logic [IDX_W-1:0] clamp_index(longint value);
      if (value < 0) return '0;
      if (value > longint'(INDEX_MAX)) return INDEX_MAX;
      return value[IDX_W-1:0];
   endfunction

   function automatic converted_pixel_type convert_pixel(logic [CH_W-1:0] red,
                                                         logic [CH_W-1:0] green,
                                                         logic [CH_W-1:0] blue,
                                                         logic eol);
      longint              chan [3];
      longint              sum;
      longint              scaled;
      longint              idx;
      converted_pixel_type res;
      chan[0] = longint'(red);
      chan[1] = longint'(green);
      chan[2] = longint'(blue);
      sum = 0;
      res.end_of_line_out = eol;
      res.is_index = 1'b1;
      res.pixel_out = '0;
      case (shadow_cfg.color_mode)
         MODE_DIRECT: begin
            res.pixel_out = {red, green, blue};
            res.is_index = 1'b0;
         end
         MODE_COMPONENT: begin
            for (int i = 0; i < 3; i++)
               sum += ((lane_of(shadow_cfg.component_weights, i) * chan[i]) >> 8)
                      & lane_of(shadow_cfg.component_masks, i);
            res.pixel_out = PIX_W'(clamp_index(sum));
         end
         MODE_RANGE: begin
            for (int i = 0; i < 3; i++)
               sum += lane_of(shadow_cfg.range_weights, i) * chan[i];
            scaled = (sum * longint'(shadow_cfg.range_scale)) >> 22;
            idx = longint'($signed(shadow_cfg.range_base)) + scaled;
            if (idx > longint'(shadow_cfg.range_limit))
               idx = longint'(shadow_cfg.range_limit);
            res.pixel_out = PIX_W'(clamp_index(idx));
         end
         default: begin
            res.pixel_out = '0;
         end
      endcase
      return res;
   endfunction

   function automatic void write_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_COLOR_MODE:        shadow_cfg.color_mode = data[1:0];
         REG_COMPONENT_WEIGHTS: shadow_cfg.component_weights = data;
         REG_COMPONENT_MASKS:   shadow_cfg.component_masks = data;
         REG_RANGE_WEIGHTS:     shadow_cfg.range_weights = data;
         REG_RANGE_BASE:        shadow_cfg.range_base = data[8:0];
         REG_RANGE_LIMIT:       shadow_cfg.range_limit = data[7:0];
         REG_RANGE_SCALE:       shadow_cfg.range_scale = data[15:0];
         default: ;
      endcase
   endfunction

   function automatic void check_field(string field_name, logic [PIX_W-1:0] want,
                                       logic [PIX_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field_name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      converted_pixel_type got_pixel;
      converted_pixel_type want_pixel;
      if (reset) begin
         shadow_cfg.color_mode        = MODE_DIRECT;
         shadow_cfg.component_weights = '0;
         shadow_cfg.component_masks   = '0;
         shadow_cfg.range_weights     = '0;
         shadow_cfg.range_base        = '0;
         shadow_cfg.range_limit       = RANGE_LIMIT_RST;
         shadow_cfg.range_scale       = RANGE_SCALE_RST;
         expected_pixels.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_pixels.push_back(convert_pixel(req_mon.red, req_mon.green,
                                                    req_mon.blue, req_mon.end_of_line));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_pixel.pixel_out       = rsp_mon.pixel_out;
            got_pixel.is_index        = rsp_mon.is_index;
            got_pixel.end_of_line_out = rsp_mon.end_of_line_out;
            if (expected_pixels.size() == 0) begin
               $display("%0t: response beat with nothing pending, expected none actual %h",
                        $time, got_pixel);
               errors++;
            end else begin
               want_pixel = expected_pixels.pop_front();
               check_field("pixel_out", want_pixel.pixel_out, got_pixel.pixel_out);
               check_field("is_index", PIX_W'(want_pixel.is_index),
                           PIX_W'(got_pixel.is_index));
               check_field("end_of_line_out", PIX_W'(want_pixel.end_of_line_out),
                           PIX_W'(got_pixel.end_of_line_out));
            end
         end
         if (csr_we)
            write_register(csr_index, csr_wdata);
      end
      fail_count <= errors;
      pending    <= expected_pixels.size();
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the RGB to color index converter: a directed pass over the
// field extremes and every color mode, then randomized register settings,
// each followed by a burst of random pixels under varying request and
// response idling, including one long response stall. The pixel checker
// does the prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import rci_pkg::*;

   localparam int PIPE_LATENCY   = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 200;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_PIXELS   = 54;

   localparam logic [1:0]           MODE_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED  = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_taken    = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   rci_req_if req_bus ();
   rci_rsp_if rsp_bus ();

   rgb_to_color_index_converter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rci_pixel_checker pixel_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: random back-pressure plus one long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_taken != hold_requests) begin
         rsp_bus.ready <= 1'b0;
         hold_taken <= hold_requests;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [CH_W-1:0] random_channel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return CH_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_lanes(logic [LANE_W-1:0] lane_max);
      logic [CSR_DATA_W-1:0] word;
      word = '0;
      case ($urandom_range(0, 7))
         0: word = '0;
         1: word = '1;
         default: begin
            for (int i = 0; i < 3; i++)
               word[i * LANE_W +: LANE_W] = LANE_W'($urandom_range(0, lane_max));
         end
      endcase
      return word;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
                             input logic [CH_W-1:0] blue, input logic eol);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.red         <= red;
      req_bus.green       <= green;
      req_bus.blue        <= blue;
      req_bus.end_of_line <= eol;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // stop offering beats and wait out every pending response
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   initial begin
      logic [1:0]        mode_pick;
      logic [LANE_W-1:0] scale_pick;
      int                phase;
      int                n;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = REG_COLOR_MODE;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.red         = '0;
      req_bus.green       = '0;
      req_bus.blue        = '0;
      req_bus.end_of_line = 1'b0;
      rsp_bus.ready       = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // direct packing straight out of reset
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_pixel(8'hA5, 8'h5A, 8'h0F, 1'b0);
      send_pixel(8'h5A, 8'hA5, 8'hF0, 1'b1);
      drain();

      // component, saturated weights
      write_csr(REG_COLOR_MODE, CSR_DATA_W'(MODE_COMPONENT));
      write_csr(REG_COMPONENT_WEIGHTS, '1);
      write_csr(REG_COMPONENT_MASKS, '1);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
      send_pixel(8'h01, 8'h01, 8'h01, 1'b0);
      drain();

      // component, partial masks
      write_csr(REG_COMPONENT_WEIGHTS, {16'h0100, 16'h0080, 16'h0040});
      write_csr(REG_COMPONENT_MASKS, {16'h00F0, 16'hFFFF, 16'h000F});
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h12, 8'h34, 8'h56, 1'b1);
      drain();

      // range, every field at its top
      write_csr(REG_COLOR_MODE, CSR_DATA_W'(MODE_RANGE));
      write_csr(REG_RANGE_WEIGHTS, '1);
      write_csr(REG_RANGE_SCALE, CSR_DATA_W'(16'hFFFF));
      write_csr(REG_RANGE_BASE, CSR_DATA_W'(9'h0FF));
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
      drain();

      write_csr(REG_RANGE_LIMIT, CSR_DATA_W'(8'h40));
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      drain();

      // most negative base pushes the index below zero
      write_csr(REG_RANGE_BASE, CSR_DATA_W'(9'h100));
      write_csr(REG_RANGE_WEIGHTS, {16'h1333, 16'h2666, 16'h0666});
      write_csr(REG_RANGE_SCALE, CSR_DATA_W'(RANGE_SCALE_RST));
      write_csr(REG_RANGE_LIMIT, CSR_DATA_W'(RANGE_LIMIT_RST));
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h80, 8'h40, 8'h20, 1'b1);
      drain();

      write_csr(REG_COLOR_MODE, CSR_DATA_W'(MODE_UNUSED));
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_pixel(8'h3C, 8'hC3, 8'h99, 1'b0);
      drain();

      // stray index must not disturb anything
      write_csr(REG_UNUSED, '1);
      send_pixel(8'h77, 8'h88, 8'h99, 1'b1);
      drain();

      // upper data bits beyond the mode field are dropped
      write_csr(REG_COLOR_MODE, {46'h3FFF_FFFF_FFFF, MODE_DIRECT});
      send_pixel(8'h01, 8'h80, 8'hFE, 1'b0);
      drain();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 4) begin
            send_idle_pct = 21;
            recv_idle_pct <= 81;
         end else if (phase < 8) begin
            send_idle_pct = 81;
            recv_idle_pct <= 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         case (phase % 4)
            0: mode_pick = MODE_COMPONENT;
            1: mode_pick = MODE_RANGE;
            2: mode_pick = MODE_DIRECT;
            default: mode_pick = 2'($urandom_range(0, 3));
         endcase
         case ($urandom_range(0, 3))
            0: scale_pick = '0;
            1: scale_pick = '1;
            default: scale_pick = LANE_W'($urandom_range(64, 512));
         endcase
         write_csr(REG_COLOR_MODE, CSR_DATA_W'(mode_pick));
         write_csr(REG_COMPONENT_WEIGHTS, random_lanes(16'h0080));
         write_csr(REG_COMPONENT_MASKS, $urandom_range(0, 1) ? '1 : random_lanes(16'hFFFF));
         write_csr(REG_RANGE_WEIGHTS, random_lanes(16'h2000));
         write_csr(REG_RANGE_BASE, CSR_DATA_W'($urandom_range(0, 511)));
         write_csr(REG_RANGE_LIMIT,
                   CSR_DATA_W'($urandom_range(0, 1) ? RANGE_LIMIT_RST
                                                    : 8'($urandom_range(0, 255))));
         write_csr(REG_RANGE_SCALE, CSR_DATA_W'(scale_pick));

         // last burst runs into a long response stall to back up the pipe
         if (phase == RANDOM_PHASES - 1)
            hold_requests <= hold_requests + 1;
         for (n = 0; n < PHASE_PIXELS; n++)
            send_pixel(random_channel(), random_channel(), random_channel(),
                       $urandom_range(0, 7) == 0);
         drain();
      end

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
src/rci_pkg.sv
src/rci_if.sv
src/rci_csr.sv
src/rgb_to_color_index_converter_unit.sv
bench/rci_pixel_checker.sv
bench/tb_top.sv
